// ===== rtl/core/undirected_graph_cycle_check_macros.svh =====
// Assertion macros for the undirected graph cycle check block.
// Included by the top level; no other dependencies.
`ifndef UNDIRECTED_GRAPH_CYCLE_CHECK_MACROS_SVH
`define UNDIRECTED_GRAPH_CYCLE_CHECK_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is low
`define UGCC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ugcc assertion failed");
// Next-cycle implication, disabled while reset is low
`define UGCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ugcc assertion failed");
`else
`define UGCC_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define UGCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/ugcc_pkg.sv =====
// Shared constants and types for the undirected graph cycle check block.
// No dependencies; used by the channel interfaces and the top level.
package ugcc_pkg;

    // Default storage sizes
    localparam int unsigned UGCC_MAX_NODES   = 64;
    localparam int unsigned UGCC_MAX_ENTRIES = 256;

    // Payload field widths
    localparam int unsigned UGCC_ACT_W  = 2;
    localparam int unsigned UGCC_NODE_W = 6;
    localparam int unsigned UGCC_CFG_W  = 7;

    localparam logic [UGCC_CFG_W-1:0] UGCC_NUM_NODES_RST = 7'd64;

    // Action codes; the fourth code is unused and answers with zeros
    localparam logic [UGCC_ACT_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [UGCC_ACT_W-1:0] ACT_CHECK = 2'd1;
    localparam logic [UGCC_ACT_W-1:0] ACT_CLEAR = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_ADD_LINK,
        S_CLR,
        S_CHK_CLR,
        S_CHK_ROOT,
        S_CHK_ROOTV,
        S_WALK,
        S_POP_WAIT,
        S_W_ENT,
        S_W_VIS,
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/ugcc_ifs.sv =====
// Valid/ready channel interfaces of the undirected graph cycle check block.
// Depends on ugcc_pkg for the payload widths.
interface ugcc_in_if;
    logic                               valid;
    logic                               ready;
    logic [ugcc_pkg::UGCC_ACT_W-1:0]    action;
    logic [ugcc_pkg::UGCC_NODE_W-1:0]   node_a;
    logic [ugcc_pkg::UGCC_NODE_W-1:0]   node_b;

    modport source (output valid, action, node_a, node_b, input ready);
    modport sink   (input valid, action, node_a, node_b, output ready);
endinterface

interface ugcc_out_if;
    logic valid;
    logic ready;
    logic cycle_found;
    logic status;

    modport source (output valid, cycle_found, status, input ready);
    modport sink   (input valid, cycle_found, status, output ready);
endinterface

interface ugcc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ugcc_pkg::UGCC_CFG_W-1:0]    num_nodes;

    modport source (output valid, num_nodes, input ready);
    modport sink   (input valid, num_nodes, output ready);
endinterface

// ===== rtl/core/undirected_graph_cycle_check.sv =====
// Undirected graph cycle check: adjacency store, sequencer and depth-first walk.
// Depends on ugcc_pkg, the channel interfaces in ugcc_ifs.sv and the macros header.
//
//   channel  | dir | payload                       | transaction
//   ---------+-----+-------------------------------+------------------------------
//   i_cfg    | in  | num_nodes                     | root count for checks
//   i_in     | in  | action, node_a, node_b        | add edge, check, clear
//   o_out    | out | cycle_found, status           | one result per input item
//
// After reset a pass over all MAX_NODES nodes empties the lists; i_in is not ready then.
// Edge add: two list appends through the node and entry memories.
// Clear: a sweep over the node memory that empties every list.
// Check: a pass clears the visited marks, then the walk handles each root and each list
// entry in turn, through the visited, node, entry and stack memories.
// One item is in work at a time; a finished result waits in the output register while
// the next transaction is taken.
`include "undirected_graph_cycle_check_macros.svh"

module undirected_graph_cycle_check #(
    parameter int unsigned MAX_NODES   = ugcc_pkg::UGCC_MAX_NODES,
    parameter int unsigned MAX_ENTRIES = ugcc_pkg::UGCC_MAX_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ugcc_cfg_if.sink    i_cfg,
    ugcc_in_if.sink     i_in,
    ugcc_out_if.source  o_out
);
    import ugcc_pkg::*;

    localparam int unsigned NW = $clog2(MAX_NODES);
    localparam int unsigned AW = $clog2(MAX_ENTRIES);
    localparam int unsigned EW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned DW = NW + 1;
    localparam logic [EW-1:0] LIST_EMPTY = EW'(MAX_ENTRIES);
    localparam logic [NW-1:0] NODE_LAST  = NW'(MAX_NODES - 1);

    typedef struct packed {
        logic [NW-1:0] node;
        logic          has_par;
        logic [NW-1:0] par;
        logic [EW-1:0] cur;
    } t_frame;

    typedef struct packed {
        logic [EW-1:0] head;
        logic [AW-1:0] tail;
    } t_node_rec;

    // Memories
    logic      r_vis_mem  [MAX_NODES];
    t_node_rec r_node_mem [MAX_NODES];
    logic [NW-1:0] r_tgt_mem [MAX_ENTRIES];
    logic [EW-1:0] r_nxt_mem [MAX_ENTRIES];
    t_frame    r_stk_mem  [MAX_NODES];

    logic          r_vis_rd;
    t_node_rec     r_node_rd;
    logic [NW-1:0] r_tgt_rd;
    logic [EW-1:0] r_nxt_rd;
    t_frame        r_stk_rd;

    // Memory port controls
    logic          vis_we, vis_wd, vis_re;
    logic [NW-1:0] vis_wa, vis_ra;
    logic          node_we, node_re;
    logic [NW-1:0] node_wa, node_ra;
    t_node_rec     node_wd;
    logic          tgt_we, nxt_we, ent_re;
    logic [AW-1:0] tgt_wa, nxt_wa, ent_ra;
    logic [NW-1:0] tgt_wd;
    logic [EW-1:0] nxt_wd;
    logic          stk_we, stk_re;
    logic [NW-1:0] stk_wa, stk_ra;
    t_frame        stk_wd;

    // Sequencer registers
    t_state        r_state, n_state;
    logic [NW-1:0] r_sweep, n_sweep;
    logic [NW-1:0] r_a, n_a, r_b, n_b;
    logic          r_phase, n_phase;
    logic [EW-1:0] r_count, n_count;
    logic [DW-1:0] r_root, n_root;
    logic [DW-1:0] r_depth, n_depth;
    t_frame        r_top, n_top;
    logic          r_res_cyc, n_res_cyc;
    logic          r_res_stat, n_res_stat;
    logic          r_out_valid, r_out_cyc, r_out_stat;
    logic [UGCC_CFG_W-1:0] r_num_nodes;

    logic          in_ready, res_load;
    logic          in_bad, store_full;
    logic [DW-1:0] roots_lim;
    logic [NW-1:0] add_own, add_tgt;
    logic [AW-1:0] slot;

    // Configuration register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_nodes <= UGCC_NUM_NODES_RST;
        end else if (i_cfg.valid) begin
            r_num_nodes <= i_cfg.num_nodes;
        end
    end

    // Clamp root count to the node store
    assign roots_lim = ({25'd0, r_num_nodes} >= 32'(MAX_NODES)) ? DW'(MAX_NODES)
                                                               : DW'(r_num_nodes);

    assign in_bad     = (32'(i_in.node_a) >= MAX_NODES) || (32'(i_in.node_b) >= MAX_NODES);
    assign store_full = (32'(r_count) + 32'd2) > MAX_ENTRIES;

    assign add_own = r_phase ? r_b : r_a;
    assign add_tgt = r_phase ? r_a : r_b;
    assign slot    = r_count[AW-1:0];

    // Next state, memory controls and walk bookkeeping
    always_comb begin
        n_state    = r_state;
        n_sweep    = r_sweep;
        n_a        = r_a;
        n_b        = r_b;
        n_phase    = r_phase;
        n_count    = r_count;
        n_root     = r_root;
        n_depth    = r_depth;
        n_top      = r_top;
        n_res_cyc  = r_res_cyc;
        n_res_stat = r_res_stat;
        in_ready   = 1'b0;
        res_load   = 1'b0;
        vis_we  = 1'b0; vis_wa  = '0; vis_wd = 1'b0; vis_re = 1'b0; vis_ra = '0;
        node_we = 1'b0; node_wa = '0; node_wd = '0;  node_re = 1'b0; node_ra = '0;
        tgt_we  = 1'b0; tgt_wa  = '0; tgt_wd = '0;
        nxt_we  = 1'b0; nxt_wa  = '0; nxt_wd = '0;
        ent_re  = 1'b0; ent_ra  = '0;
        stk_we  = 1'b0; stk_wa  = '0; stk_wd = '0;  stk_re = 1'b0; stk_ra = '0;

        unique case (r_state)
            // Empty every list and drop visited marks, one node a cycle
            S_INIT, S_CLR: begin
                node_we = 1'b1;
                node_wa = r_sweep;
                node_wd = '{head: LIST_EMPTY, tail: '0};
                vis_we  = 1'b1;
                vis_wa  = r_sweep;
                vis_wd  = 1'b0;
                n_sweep = r_sweep + NW'(1);
                if (r_sweep == NODE_LAST) begin
                    n_sweep = '0;
                    n_state = (r_state == S_INIT) ? S_IDLE : S_DONE;
                end
            end
            // Take a transaction and decode the action
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    n_a        = NW'(i_in.node_a);
                    n_b        = NW'(i_in.node_b);
                    n_phase    = 1'b0;
                    n_res_cyc  = 1'b0;
                    n_res_stat = 1'b0;
                    n_sweep    = '0;
                    unique case (i_in.action)
                        ACT_ADD: begin
                            if (in_bad || store_full) begin
                                n_res_stat = 1'b1;
                                n_state    = S_DONE;
                            end else begin
                                n_state = S_ADD_RD;
                            end
                        end
                        ACT_CHECK: n_state = S_CHK_CLR;
                        ACT_CLEAR: begin
                            n_count = '0;
                            n_state = S_CLR;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            // Fetch head and tail of the owning list
            S_ADD_RD: begin
                node_re = 1'b1;
                node_ra = add_own;
                n_state = S_ADD_WR;
            end
            // Write the new entry and move the tail
            S_ADD_WR: begin
                tgt_we  = 1'b1;
                tgt_wa  = slot;
                tgt_wd  = add_tgt;
                nxt_we  = 1'b1;
                nxt_wa  = slot;
                nxt_wd  = LIST_EMPTY;
                node_we = 1'b1;
                node_wa = add_own;
                if (r_node_rd.head == LIST_EMPTY) begin
                    node_wd = '{head: r_count, tail: slot};
                    n_count = r_count + EW'(1);
                    n_phase = 1'b1;
                    n_state = r_phase ? S_DONE : S_ADD_RD;
                end else begin
                    node_wd = '{head: r_node_rd.head, tail: slot};
                    n_state = S_ADD_LINK;
                end
            end
            // Link the old tail to the new entry
            S_ADD_LINK: begin
                nxt_we  = 1'b1;
                nxt_wa  = r_node_rd.tail;
                nxt_wd  = r_count;
                n_count = r_count + EW'(1);
                n_phase = 1'b1;
                n_state = r_phase ? S_DONE : S_ADD_RD;
            end
            // Clear visited marks before a check
            S_CHK_CLR: begin
                vis_we  = 1'b1;
                vis_wa  = r_sweep;
                vis_wd  = 1'b0;
                n_sweep = r_sweep + NW'(1);
                if (r_sweep == NODE_LAST) begin
                    n_sweep = '0;
                    n_root  = '0;
                    n_state = S_CHK_ROOT;
                end
            end
            // Next root, or finish without a cycle
            S_CHK_ROOT: begin
                if (r_root >= roots_lim) begin
                    n_state = S_DONE;
                end else begin
                    vis_re  = 1'b1;
                    vis_ra  = r_root[NW-1:0];
                    node_re = 1'b1;
                    node_ra = r_root[NW-1:0];
                    n_state = S_CHK_ROOTV;
                end
            end
            // Skip a visited root, else open its walk
            S_CHK_ROOTV: begin
                if (r_vis_rd) begin
                    n_root  = r_root + DW'(1);
                    n_state = S_CHK_ROOT;
                end else begin
                    vis_we  = 1'b1;
                    vis_wa  = r_root[NW-1:0];
                    vis_wd  = 1'b1;
                    n_top   = '{node: r_root[NW-1:0], has_par: 1'b0, par: '0,
                                cur: r_node_rd.head};
                    n_depth = DW'(1);
                    n_state = S_WALK;
                end
            end
            // Pop an exhausted frame or fetch the next list entry
            S_WALK: begin
                if (r_top.cur == LIST_EMPTY) begin
                    n_depth = r_depth - DW'(1);
                    if (r_depth == DW'(1)) begin
                        n_root  = r_root + DW'(1);
                        n_state = S_CHK_ROOT;
                    end else begin
                        stk_re  = 1'b1;
                        stk_ra  = NW'(r_depth - DW'(2));
                        n_state = S_POP_WAIT;
                    end
                end else begin
                    ent_re  = 1'b1;
                    ent_ra  = r_top.cur[AW-1:0];
                    n_state = S_W_ENT;
                end
            end
            // Restore the frame below
            S_POP_WAIT: begin
                n_top   = r_stk_rd;
                n_state = S_WALK;
            end
            // Advance the cursor and look up the neighbor
            S_W_ENT: begin
                n_top.cur = r_nxt_rd;
                vis_re    = 1'b1;
                vis_ra    = r_tgt_rd;
                node_re   = 1'b1;
                node_ra   = r_tgt_rd;
                n_state   = S_W_VIS;
            end
            // Descend into a new neighbor, skip the parent, or flag a back edge
            S_W_VIS: begin
                if (!r_vis_rd) begin
                    stk_we  = 1'b1;
                    stk_wa  = NW'(r_depth - DW'(1));
                    stk_wd  = r_top;
                    vis_we  = 1'b1;
                    vis_wa  = r_tgt_rd;
                    vis_wd  = 1'b1;
                    n_top   = '{node: r_tgt_rd, has_par: 1'b1, par: r_top.node,
                                cur: r_node_rd.head};
                    n_depth = r_depth + DW'(1);
                    n_state = S_WALK;
                end else if (!(r_top.has_par && (r_tgt_rd == r_top.par))) begin
                    n_res_cyc = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_WALK;
                end
            end
            // Hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    res_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_sweep <= '0;
            r_count <= '0;
            r_depth <= '0;
            r_root  <= '0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_count <= n_count;
            r_depth <= n_depth;
            r_root  <= n_root;
        end
    end

    // Working payload
    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_phase    <= n_phase;
        r_top      <= n_top;
        r_res_cyc  <= n_res_cyc;
        r_res_stat <= n_res_stat;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_cyc  <= r_res_cyc;
            r_out_stat <= r_res_stat;
        end
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.cycle_found = r_out_cyc;
    assign o_out.status      = r_out_stat;

    // Visited marks
    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            r_vis_mem[vis_wa] <= vis_wd;
        end
        if (vis_re) begin
            r_vis_rd <= r_vis_mem[vis_ra];
        end
    end

    // List heads and tails
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            r_node_mem[node_wa] <= node_wd;
        end
        if (node_re) begin
            r_node_rd <= r_node_mem[node_ra];
        end
    end

    // Entry targets
    always_ff @(posedge i_clk) begin
        if (tgt_we) begin
            r_tgt_mem[tgt_wa] <= tgt_wd;
        end
        if (ent_re) begin
            r_tgt_rd <= r_tgt_mem[ent_ra];
        end
    end

    // Entry links
    always_ff @(posedge i_clk) begin
        if (nxt_we) begin
            r_nxt_mem[nxt_wa] <= nxt_wd;
        end
        if (ent_re) begin
            r_nxt_rd <= r_nxt_mem[ent_ra];
        end
    end

    // Walk stack, frames below the top
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_wa] <= stk_wd;
        end
        if (stk_re) begin
            r_stk_rd <= r_stk_mem[stk_ra];
        end
    end

    // Checks
    `UGCC_ASSERT_NOW(a_depth_bound, i_clk, i_rst_n, 1'b1, r_depth <= DW'(MAX_NODES))
    `UGCC_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, 32'(r_count) <= MAX_ENTRIES)
    `UGCC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in.valid && i_in.ready, r_state != S_IDLE)
    `UGCC_ASSERT_NOW(a_result_excl, i_clk, i_rst_n, o_out.valid, !(o_out.cycle_found && o_out.status))

endmodule
